// ===== rtl/fdpd_pkg.sv =====
package fdpd_pkg;

    // Field widths at the ports
    localparam int DIST_W     = 13;
    localparam int TIME_W     = 32;
    localparam int DRIVE_W    = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register widths
    localparam int GAIN_W  = 16;
    localparam int GAP_W   = 11;
    localparam int DELAY_W = 16;
    localparam int ILIM_W  = 16;
    localparam int START_W = 10;

    // Datapath widths
    localparam int ERR_W    = DIST_W + 1;       // dist - follow, signed
    localparam int MAG_W    = DIST_W;           // positive error magnitude
    localparam int DERIV_W  = ERR_W + 1;        // err - previous_error, signed
    localparam int INTEG_W  = ILIM_W;           // integral never exceeds the clamp
    localparam int PROD_P_W = GAIN_W + MAG_W;
    localparam int PROD_I_W = GAIN_W + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W    = PROD_I_W + 2;
    localparam int PID_W    = SUM_W - 8;        // after the Q8.8 scale-down
    localparam int TGT_W    = PID_W + 1;        // start_drive + pid

    // Defaults of the top-level parameters
    localparam int DRIVE_MAX_DEF   = 1000;
    localparam int DRIVE_STEP_DEF  = 50;
    localparam int RANGE_LIMIT_DEF = 2000;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd256;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd0;
    localparam logic [GAP_W-1:0]   FOLLOW_RST      = 11'd300;
    localparam logic [GAP_W-1:0]   BRAKE_DIST_RST  = 11'd100;
    localparam logic [DELAY_W-1:0] BRAKE_DELAY_RST = 16'd100;
    localparam logic [ILIM_W-1:0]  INTEG_LIMIT_RST = 16'd1000;
    localparam logic [START_W-1:0] START_DRIVE_RST = 10'd300;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOLLOW = 2'd0,
        STATUS_SEARCH = 2'd1,
        STATUS_EMERG  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_FOLLOW      = 3'd3,
        CFG_BRAKE_DIST  = 3'd4,
        CFG_BRAKE_DELAY = 3'd5,
        CFG_INTEG_LIMIT = 3'd6,
        CFG_START_DRIVE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [GAP_W-1:0]   follow_distance_mm;
        logic [GAP_W-1:0]   brake_distance_mm;
        logic [DELAY_W-1:0] brake_delay_ms;
        logic [ILIM_W-1:0]  integral_limit;
        logic [START_W-1:0] start_drive;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic [TIME_W-1:0] time_ms;
    } meas_t;

    // After error / state update
    typedef struct packed {
        status_t                    kind;
        logic                       err_pos;
        logic [MAG_W-1:0]           err_mag;
        logic signed [DERIV_W-1:0]  deriv;
        logic [INTEG_W-1:0]         integral;
    } err_stage_t;

    // After the gain multipliers
    typedef struct packed {
        status_t                    kind;
        logic                       err_pos;
        logic [PROD_P_W-1:0]        prod_p;
        logic [PROD_I_W-1:0]        prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prod_stage_t;

    // After scale-down and saturation
    typedef struct packed {
        status_t                    kind;
        logic signed [DRIVE_W-1:0]  target;
    } tgt_stage_t;

endpackage

// ===== rtl/fdpd_meas_if.sv =====
interface fdpd_meas_if;
    logic                         valid;
    logic                         ready;
    logic [fdpd_pkg::DIST_W-1:0]  distance_mm;
    logic [fdpd_pkg::TIME_W-1:0]  time_ms;

    modport source (output valid, output distance_mm, output time_ms, input ready);
    modport sink   (input valid, input distance_mm, input time_ms, output ready);
endinterface

// ===== rtl/fdpd_cmd_if.sv =====
interface fdpd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic signed [fdpd_pkg::DRIVE_W-1:0] drive_level;
    logic                                hard_brake;
    logic [fdpd_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output drive_level, output hard_brake, output status,
                    input ready);
    modport sink   (input valid, input drive_level, input hard_brake, input status,
                    output ready);
endinterface

// ===== rtl/fdpd_cfg_if.sv =====
interface fdpd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fdpd_pkg::CFG_IDX_W-1:0]   index;
    logic [fdpd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/follow_distance_pid_drive.sv =====
// Follow-distance drive controller. Each measurement request (gap in mm and a
// millisecond time stamp) yields exactly one drive command: searching with zero
// drive when the gap is 0 or at/above RANGE_LIMIT, an emergency hard brake once
// the gap has stayed below brake_distance_mm for longer than brake_delay_ms,
// and otherwise a PID step (Q8.8 gains, positive-only clamped integral) whose
// target is capped at +/-DRIVE_MAX and approached in steps of DRIVE_STEP.
// The block takes one request per clock while the command output is not stalled;
// the path is five registers (input, error/state update, multipliers, target,
// command), each with its own valid, so a stalled command output only holds
// back requests once the pipeline has filled. Configuration writes are always
// taken and should be done while no request is in flight.
module follow_distance_pid_drive #(
    parameter int DRIVE_MAX   = fdpd_pkg::DRIVE_MAX_DEF,
    parameter int DRIVE_STEP  = fdpd_pkg::DRIVE_STEP_DEF,
    parameter int RANGE_LIMIT = fdpd_pkg::RANGE_LIMIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fdpd_cfg_if.sink     cfg,
    fdpd_meas_if.sink    meas,
    fdpd_cmd_if.source   cmd
);
    import fdpd_pkg::*;

    cfg_t        cfg_reg;
    meas_t       meas_reg;
    logic        meas_valid_reg;
    logic        err_in_ready;
    logic        err_valid;
    err_stage_t  err_stage;
    logic        pid_in_ready;
    logic        pid_valid;
    tgt_stage_t  tgt_stage;
    logic        slew_in_ready;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p             <= GAIN_P_RST;
            cfg_reg.gain_i             <= GAIN_I_RST;
            cfg_reg.gain_d             <= GAIN_D_RST;
            cfg_reg.follow_distance_mm <= FOLLOW_RST;
            cfg_reg.brake_distance_mm  <= BRAKE_DIST_RST;
            cfg_reg.brake_delay_ms     <= BRAKE_DELAY_RST;
            cfg_reg.integral_limit     <= INTEG_LIMIT_RST;
            cfg_reg.start_drive        <= START_DRIVE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_GAIN_P:      cfg_reg.gain_p             <= cfg.data[GAIN_W-1:0];
                CFG_GAIN_I:      cfg_reg.gain_i             <= cfg.data[GAIN_W-1:0];
                CFG_GAIN_D:      cfg_reg.gain_d             <= cfg.data[GAIN_W-1:0];
                CFG_FOLLOW:      cfg_reg.follow_distance_mm <= cfg.data[GAP_W-1:0];
                CFG_BRAKE_DIST:  cfg_reg.brake_distance_mm  <= cfg.data[GAP_W-1:0];
                CFG_BRAKE_DELAY: cfg_reg.brake_delay_ms     <= cfg.data[DELAY_W-1:0];
                CFG_INTEG_LIMIT: cfg_reg.integral_limit     <= cfg.data[ILIM_W-1:0];
                CFG_START_DRIVE: cfg_reg.start_drive        <= cfg.data[START_W-1:0];
                default:         cfg_reg.gain_p             <= cfg_reg.gain_p;
            endcase
        end
    end

    // Input register
    assign meas.ready = !meas_valid_reg || err_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg <= 1'b0;
        end
        else if (meas.ready)
        begin
            meas_valid_reg <= meas.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas.valid && meas.ready)
        begin
            meas_reg.distance_mm <= meas.distance_mm;
            meas_reg.time_ms     <= meas.time_ms;
        end
    end

    fdpd_err #(
        .RANGE_LIMIT (RANGE_LIMIT)
    ) u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (meas_valid_reg),
        .in_ready  (err_in_ready),
        .in_meas   (meas_reg),
        .out_valid (err_valid),
        .out_ready (pid_in_ready),
        .out_stage (err_stage)
    );

    fdpd_pid #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_pid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (err_valid),
        .in_ready  (pid_in_ready),
        .in_stage  (err_stage),
        .out_valid (pid_valid),
        .out_ready (slew_in_ready),
        .out_stage (tgt_stage)
    );

    fdpd_slew #(
        .DRIVE_STEP (DRIVE_STEP)
    ) u_slew (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pid_valid),
        .in_ready (slew_in_ready),
        .in_stage (tgt_stage),
        .cmd      (cmd)
    );

endmodule

// ===== rtl/fdpd_err.sv =====
module fdpd_err #(
    parameter int RANGE_LIMIT = fdpd_pkg::RANGE_LIMIT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdpd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fdpd_pkg::meas_t      in_meas,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fdpd_pkg::err_stage_t out_stage
);
    import fdpd_pkg::*;

    localparam logic [DIST_W-1:0] RANGE_LIM = DIST_W'(RANGE_LIMIT);

    logic                      valid_reg;
    err_stage_t                stage_reg;
    err_stage_t                stage_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [ERR_W-1:0]   err;
    logic [INTEG_W-1:0]        integ_reg;
    logic [INTEG_W-1:0]        integ_next;
    logic [INTEG_W:0]          integ_sum;
    logic                      pending_reg;
    logic [TIME_W-1:0]         start_reg;
    logic [TIME_W-1:0]         elapsed;
    logic                      out_of_range;
    logic                      below;
    logic                      emerg;
    logic                      load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    // Range, brake arming and emergency decision
    assign out_of_range = (in_meas.distance_mm == '0) || (in_meas.distance_mm >= RANGE_LIM);
    assign below        = in_meas.distance_mm < {{(DIST_W-GAP_W){1'b0}}, cfg.brake_distance_mm};
    assign elapsed      = in_meas.time_ms - start_reg;
    assign emerg        = !out_of_range && below && pending_reg
                          && (elapsed > {{(TIME_W-DELAY_W){1'b0}}, cfg.brake_delay_ms});

    // Error and clamped positive-only integral
    assign err = $signed({1'b0, in_meas.distance_mm})
               - $signed({{(ERR_W-GAP_W){1'b0}}, cfg.follow_distance_mm});
    assign integ_sum = {1'b0, integ_reg} + {{(INTEG_W+1-MAG_W){1'b0}}, err[MAG_W-1:0]};

    always_comb
    begin
        if (err <= 0)
        begin
            integ_next = '0;
        end
        else if (integ_sum > {1'b0, cfg.integral_limit})
        begin
            integ_next = cfg.integral_limit;
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    always_comb
    begin
        if (out_of_range)
        begin
            stage_next.kind = STATUS_SEARCH;
        end
        else if (emerg)
        begin
            stage_next.kind = STATUS_EMERG;
        end
        else
        begin
            stage_next.kind = STATUS_FOLLOW;
        end
        stage_next.err_pos  = (err > 0);
        stage_next.err_mag  = err[MAG_W-1:0];
        stage_next.deriv    = DERIV_W'(err) - DERIV_W'(prev_err_reg);
        stage_next.integral = integ_next;
    end

    // Controller state, updated as each request passes (held on an emergency request)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            pending_reg  <= 1'b0;
            start_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                if (out_of_range)
                begin
                    pending_reg <= 1'b0;
                end
                else if (!emerg)
                begin
                    if (!below)
                    begin
                        pending_reg <= 1'b0;
                    end
                    else if (!pending_reg)
                    begin
                        pending_reg <= 1'b1;
                        start_reg   <= in_meas.time_ms;
                    end
                    prev_err_reg <= err;
                    integ_reg    <= integ_next;
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ===== rtl/fdpd_pid.sv =====
module fdpd_pid #(
    parameter int DRIVE_MAX = fdpd_pkg::DRIVE_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdpd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fdpd_pkg::err_stage_t in_stage,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fdpd_pkg::tgt_stage_t out_stage
);
    import fdpd_pkg::*;

    localparam logic signed [TGT_W-1:0] MAX_T = TGT_W'(DRIVE_MAX);
    localparam logic signed [TGT_W-1:0] MIN_T = -TGT_W'(DRIVE_MAX);

    logic                       prod_valid_reg;
    prod_stage_t                prod_reg;
    prod_stage_t                prod_next;
    logic                       prod_ready;
    logic                       prod_load;
    logic                       tgt_valid_reg;
    tgt_stage_t                 tgt_reg;
    tgt_stage_t                 tgt_next;
    logic                       tgt_load;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_adj;
    logic signed [PID_W-1:0]    pid;
    logic signed [TGT_W-1:0]    raw;
    logic signed [TGT_W-1:0]    clamped;

    assign prod_ready = !tgt_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign prod_load  = in_valid && in_ready;
    assign tgt_load   = prod_valid_reg && prod_ready;
    assign out_valid  = tgt_valid_reg;
    assign out_stage  = tgt_reg;

    // Gain multipliers
    always_comb
    begin
        prod_next.kind    = in_stage.kind;
        prod_next.err_pos = in_stage.err_pos;
        prod_next.prod_p  = PROD_P_W'(cfg.gain_p) * PROD_P_W'(in_stage.err_mag);
        prod_next.prod_i  = PROD_I_W'(cfg.gain_i) * PROD_I_W'(in_stage.integral);
        prod_next.prod_d  = PROD_D_W'($signed({1'b0, cfg.gain_d})) * PROD_D_W'(in_stage.deriv);
    end

    // Q8.8 sum, truncation toward zero, start offset and saturation; zero target unless the error is positive
    assign sum = $signed({{(SUM_W-PROD_P_W){1'b0}}, prod_reg.prod_p})
               + $signed({{(SUM_W-PROD_I_W){1'b0}}, prod_reg.prod_i})
               + SUM_W'(prod_reg.prod_d);
    assign sum_adj = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
    assign pid     = sum_adj[SUM_W-1:8];
    assign raw     = $signed({{(TGT_W-START_W){1'b0}}, cfg.start_drive}) + TGT_W'(pid);

    always_comb
    begin
        if (raw > MAX_T)
        begin
            clamped = MAX_T;
        end
        else if (raw < MIN_T)
        begin
            clamped = MIN_T;
        end
        else
        begin
            clamped = raw;
        end
        tgt_next.kind   = prod_reg.kind;
        tgt_next.target = prod_reg.err_pos ? clamped[DRIVE_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            tgt_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                tgt_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_load)
        begin
            prod_reg <= prod_next;
        end
        if (tgt_load)
        begin
            tgt_reg <= tgt_next;
        end
    end

endmodule

// ===== rtl/fdpd_slew.sv =====
module fdpd_slew #(
    parameter int DRIVE_STEP = fdpd_pkg::DRIVE_STEP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fdpd_pkg::tgt_stage_t in_stage,
    fdpd_cmd_if.source           cmd
);
    import fdpd_pkg::*;

    localparam int SLEW_W = DRIVE_W + 1;
    localparam logic signed [SLEW_W-1:0] STEP = SLEW_W'(DRIVE_STEP);

    logic                       valid_reg;
    logic                       load;
    logic signed [DRIVE_W-1:0]  cur_reg;
    logic signed [DRIVE_W-1:0]  cur_next;
    logic signed [SLEW_W-1:0]   cur_up;
    logic signed [SLEW_W-1:0]   cur_dn;
    logic signed [SLEW_W-1:0]   tgt_ext;
    logic signed [DRIVE_W-1:0]  drive_reg;
    logic                       brake_reg;
    status_t                    status_reg;
    logic                       brake_next;

    assign in_ready = !valid_reg || cmd.ready;
    assign load     = in_valid && in_ready;

    // Step limit toward the target while following; zero drive when searching or braking
    assign cur_up  = SLEW_W'(cur_reg) + STEP;
    assign cur_dn  = SLEW_W'(cur_reg) - STEP;
    assign tgt_ext = SLEW_W'(in_stage.target);

    always_comb
    begin
        case (in_stage.kind)
            STATUS_FOLLOW:
            begin
                brake_next = 1'b0;
                if (tgt_ext > cur_up)
                begin
                    cur_next = cur_up[DRIVE_W-1:0];
                end
                else if (tgt_ext < cur_dn)
                begin
                    cur_next = cur_dn[DRIVE_W-1:0];
                end
                else
                begin
                    cur_next = in_stage.target;
                end
            end
            STATUS_EMERG:
            begin
                brake_next = 1'b1;
                cur_next   = '0;
            end
            default:
            begin
                brake_next = 1'b0;
                cur_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cur_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                cur_reg <= cur_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg  <= cur_next;
            brake_reg  <= brake_next;
            status_reg <= in_stage.kind;
        end
    end

    assign cmd.valid       = valid_reg;
    assign cmd.drive_level = drive_reg;
    assign cmd.hard_brake  = brake_reg;
    assign cmd.status      = status_reg;

endmodule

// ===== rtl/fdpd_checker.sv =====
module fdpd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_ready,
    input logic signed [fdpd_pkg::DRIVE_W-1:0] drive_level,
    input logic                                hard_brake,
    input logic [fdpd_pkg::STATUS_W-1:0]       status
);
    import fdpd_pkg::*;

    localparam logic signed [DRIVE_W-1:0] LIM = DRIVE_W'(DRIVE_MAX_DEF);

    // Searching commands carry no drive and no brake
    a_search_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && status == STATUS_SEARCH |-> drive_level == '0 && !hard_brake)
        else $error("searching command with drive or brake");

    // A hard brake only comes with the emergency status and zero drive
    a_brake_emerg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && hard_brake |-> status == STATUS_EMERG && drive_level == '0)
        else $error("hard brake outside emergency");

    // Drive stays within the cap
    a_drive_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> drive_level <= LIM && drive_level >= -LIM)
        else $error("drive level beyond cap");

    // A stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(drive_level)
            && $stable(hard_brake) && $stable(status))
        else $error("stalled command changed");

endmodule

bind follow_distance_pid_drive fdpd_checker u_fdpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .drive_level (cmd.drive_level),
    .hard_brake  (cmd.hard_brake),
    .status      (cmd.status)
);
